// ----- hdl/dqpi_pkg.sv -----
package dqpi_pkg;

    localparam int CURRENT_WIDTH_DEF = 16;
    localparam int GAIN_W            = 16;
    localparam int ILIM_W            = 24;
    localparam int CLIM_W            = 15;
    localparam int INTEG_W           = 25;
    localparam int VOLT_W            = 30;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 24;
    localparam int COEF_W            = 15;

    // low-pass coefficients, 0.95 and 0.05 in Q0.15
    localparam logic [COEF_W-1:0] FILT_NEW = 15'd31130;
    localparam logic [COEF_W-1:0] FILT_OLD = 15'd1638;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 16'd838;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST    = 16'd629;
    localparam logic [ILIM_W-1:0] INTEG_LIMIT_RST   = 24'd58982;
    localparam logic [CLIM_W-1:0] CURRENT_LIMIT_RST = 15'd10240;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 2'd3;

    localparam logic CMD_SET_REF = 1'b0;
    localparam logic CMD_SAMPLE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FILT,
        S_PROD,
        S_INTEG,
        S_VOLT,
        S_MERGE
    } t_state;

    // per-step strobes shared by both lanes
    typedef struct packed {
        logic load_ref;
        logic load_meas;
        logic mul;
        logic filt;
        logic prod;
        logic integ;
        logic volt;
    } t_lane_ctl;

endpackage

// ----- hdl/dqpi_lane.sv -----
module dqpi_lane #(
    parameter int CURRENT_WIDTH = dqpi_pkg::CURRENT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dqpi_pkg::t_lane_ctl                  i_ctl,
    input  logic signed [CURRENT_WIDTH-1:0]      i_target,
    input  logic signed [CURRENT_WIDTH-1:0]      i_meas,
    input  logic [dqpi_pkg::GAIN_W-1:0]          i_kp,
    input  logic [dqpi_pkg::GAIN_W-1:0]          i_ki,
    input  logic [dqpi_pkg::ILIM_W-1:0]          i_ilim,
    input  logic [dqpi_pkg::CLIM_W-1:0]          i_clim,
    output logic signed [dqpi_pkg::VOLT_W-1:0]   o_volt
);
    import dqpi_pkg::*;

    localparam int CW   = CURRENT_WIDTH;
    localparam int RC_W = ((CW > CLIM_W) ? CW : CLIM_W) + 1;
    localparam int P_W  = CW + COEF_W + 1;
    localparam int S_W  = P_W + 1;
    localparam int E_W  = CW + 1;
    localparam int KK_W = 2 * GAIN_W;
    localparam int PE_W = E_W + KK_W + 1;
    localparam int PP_W = E_W + GAIN_W + 1;
    localparam int IS_W = PE_W - 16 + 1;
    localparam int VC_W = ((PP_W - 4 + 1) > (VOLT_W + 1)) ? (PP_W - 4 + 1) : (VOLT_W + 1);

    logic signed [CW-1:0]      r_ref, n_ref;
    logic signed [CW-1:0]      r_meas;
    logic signed [CW-1:0]      r_filt, n_filt;
    logic signed [P_W-1:0]     r_p_new, r_p_old;
    logic [KK_W-1:0]           r_kk;
    logic signed [E_W-1:0]     r_err, n_err;
    logic signed [PE_W-1:0]    r_pe;
    logic signed [PP_W-1:0]    r_pp;
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [VOLT_W-1:0]  r_volt, n_volt;

    logic signed [RC_W-1:0]    tgt_ext, clim_ext, ref_c;
    logic signed [S_W-1:0]     filt_sum;
    logic signed [IS_W-1:0]    integ_sum, ilim_ext;
    logic signed [VC_W-1:0]    volt_sum, vmax_ext, vmin_ext;

    // reference clamp to +/- current limit
    always_comb begin
        tgt_ext  = RC_W'(i_target);
        clim_ext = $signed({{(RC_W-CLIM_W){1'b0}}, i_clim});
        if (tgt_ext > clim_ext) begin
            ref_c = clim_ext;
        end else if (tgt_ext < -clim_ext) begin
            ref_c = -clim_ext;
        end else begin
            ref_c = tgt_ext;
        end
        n_ref = ref_c[CW-1:0];
    end

    // filter: sum of the two products, floor shift by 15
    always_comb begin
        filt_sum = S_W'(r_p_new) + S_W'(r_p_old);
        n_filt   = filt_sum[CW+COEF_W-1:COEF_W];
        n_err    = E_W'(r_ref) - E_W'(n_filt);
    end

    // integrator with symmetric clamp
    always_comb begin
        integ_sum = IS_W'($signed(r_pe[PE_W-1:16])) + IS_W'(r_integ);
        ilim_ext  = $signed({{(IS_W-ILIM_W){1'b0}}, i_ilim});
        if (integ_sum > ilim_ext) begin
            n_integ = INTEG_W'(ilim_ext);
        end else if (integ_sum < -ilim_ext) begin
            n_integ = INTEG_W'(-ilim_ext);
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end
    end

    // voltage = integrator + kp*err/16, saturated to the output range
    always_comb begin
        volt_sum = VC_W'(r_integ) + VC_W'($signed(r_pp[PP_W-1:4]));
        vmax_ext = $signed({{(VC_W-VOLT_W+1){1'b0}}, {(VOLT_W-1){1'b1}}});
        vmin_ext = -vmax_ext - VC_W'(1);
        if (volt_sum > vmax_ext) begin
            n_volt = VOLT_W'(vmax_ext);
        end else if (volt_sum < vmin_ext) begin
            n_volt = VOLT_W'(vmin_ext);
        end else begin
            n_volt = volt_sum[VOLT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= '0;
            r_filt  <= '0;
            r_integ <= '0;
        end else begin
            if (i_ctl.load_ref) begin
                r_ref <= n_ref;
            end
            if (i_ctl.filt) begin
                r_filt <= n_filt;
            end
            if (i_ctl.integ) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_meas) begin
            r_meas <= i_meas;
        end
        if (i_ctl.mul) begin
            r_p_new <= P_W'(r_meas) * $signed({1'b0, FILT_NEW});
            r_p_old <= P_W'(r_filt) * $signed({1'b0, FILT_OLD});
            r_kk    <= KK_W'(i_ki) * KK_W'(i_kp);
        end
        if (i_ctl.filt) begin
            r_err <= n_err;
        end
        if (i_ctl.prod) begin
            r_pe <= PE_W'(r_err) * $signed({1'b0, r_kk});
            r_pp <= PP_W'(r_err) * $signed({1'b0, i_kp});
        end
        if (i_ctl.volt) begin
            r_volt <= n_volt;
        end
    end

    assign o_volt = r_volt;

endmodule

// ----- hdl/dqpi_merge.sv -----
module dqpi_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic signed [dqpi_pkg::VOLT_W-1:0] i_volt_d,
    input  logic signed [dqpi_pkg::VOLT_W-1:0] i_volt_q,
    input  logic                               i_ready,
    output logic                               o_free,
    output logic                               o_valid,
    output logic signed [dqpi_pkg::VOLT_W-1:0] o_volt_d,
    output logic signed [dqpi_pkg::VOLT_W-1:0] o_volt_q
);
    import dqpi_pkg::*;

    logic                     r_valid;
    logic signed [VOLT_W-1:0] r_volt_d, r_volt_q;

    // slot is free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_volt_d <= i_volt_d;
            r_volt_q <= i_volt_q;
        end
    end

    assign o_valid  = r_valid;
    assign o_volt_d = r_volt_d;
    assign o_volt_q = r_volt_q;

endmodule

// ----- hdl/dq_current_pi_regulator.sv -----
// dq-axis PI current regulator with integrator clamp and input low-pass.
//
// Input channel (i_in_valid / o_in_ready): one request per handshake.
//   cmd set-ref : clamps target_d/target_q to +/- current_limit and stores
//                 them; no result.
//   cmd sample  : filters meas_d/meas_q, runs the PI step on both axes and
//                 yields one result (volt_d, volt_q).
// Output channel (o_out_valid / i_out_ready): one registered result slot.
// A sample passes the lane steps in order (multiply, filter, products,
//   integrate, saturate) and is then handed over into the output slot,
//   which raises o_out_valid; both axes run in their own lane in parallel.
//   A new request is taken only in the idle state, after the hand-over.
// A held result does not block the next request: a new sample is taken and
//   worked on, and only waits in the hand-over step if the slot is still full.
// Config port: write enable, index, data; the user is to use it only
//   while the block is idle; the block itself does not enforce this.
// Reset (synchronous, active low): gains and limits to defaults, references,
//   filters and integrators to zero, output slot empty.
module dq_current_pi_regulator #(
    parameter int CURRENT_WIDTH = dqpi_pkg::CURRENT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dqpi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dqpi_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_cmd,
    input  logic signed [CURRENT_WIDTH-1:0]      i_target_q,
    input  logic signed [CURRENT_WIDTH-1:0]      i_target_d,
    input  logic signed [CURRENT_WIDTH-1:0]      i_meas_d,
    input  logic signed [CURRENT_WIDTH-1:0]      i_meas_q,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [dqpi_pkg::VOLT_W-1:0]   o_volt_d,
    output logic signed [dqpi_pkg::VOLT_W-1:0]   o_volt_q
);
    import dqpi_pkg::*;

    // config registers
    logic [GAIN_W-1:0] r_kp, r_ki;
    logic [ILIM_W-1:0] r_ilim;
    logic [CLIM_W-1:0] r_clim;

    t_state    r_state, n_state;
    t_lane_ctl lane_ctl;
    logic      in_acc;
    logic      merge_load;
    logic      merge_free;

    logic signed [VOLT_W-1:0] volt_d_lane, volt_q_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= PROP_GAIN_RST;
            r_ki   <= INTEG_GAIN_RST;
            r_ilim <= INTEG_LIMIT_RST;
            r_clim <= CURRENT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:     r_kp   <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:    r_ki   <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_LIMIT:   r_ilim <= i_cfg_data[ILIM_W-1:0];
                REG_CURRENT_LIMIT: r_clim <= i_cfg_data[CLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // step sequencer
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state            = r_state;
        lane_ctl           = '0;
        merge_load         = 1'b0;
        lane_ctl.load_ref  = in_acc && (i_cmd == CMD_SET_REF);
        lane_ctl.load_meas = in_acc && (i_cmd == CMD_SAMPLE);
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_SAMPLE)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                lane_ctl.mul = 1'b1;
                n_state      = S_FILT;
            end
            S_FILT: begin
                lane_ctl.filt = 1'b1;
                n_state       = S_PROD;
            end
            S_PROD: begin
                lane_ctl.prod = 1'b1;
                n_state       = S_INTEG;
            end
            S_INTEG: begin
                lane_ctl.integ = 1'b1;
                n_state        = S_VOLT;
            end
            S_VOLT: begin
                lane_ctl.volt = 1'b1;
                n_state       = S_MERGE;
            end
            S_MERGE: begin
                // wait here while the previous result is still held
                if (merge_free) begin
                    merge_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // d and q lanes
    dqpi_lane #(
        .CURRENT_WIDTH(CURRENT_WIDTH)
    ) u_lane_d (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_target (i_target_d),
        .i_meas   (i_meas_d),
        .i_kp     (r_kp),
        .i_ki     (r_ki),
        .i_ilim   (r_ilim),
        .i_clim   (r_clim),
        .o_volt   (volt_d_lane)
    );

    dqpi_lane #(
        .CURRENT_WIDTH(CURRENT_WIDTH)
    ) u_lane_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_target (i_target_q),
        .i_meas   (i_meas_q),
        .i_kp     (r_kp),
        .i_ki     (r_ki),
        .i_ilim   (r_ilim),
        .i_clim   (r_clim),
        .o_volt   (volt_q_lane)
    );

    // both lanes into one result slot
    dqpi_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (merge_load),
        .i_volt_d (volt_d_lane),
        .i_volt_q (volt_q_lane),
        .i_ready  (i_out_ready),
        .o_free   (merge_free),
        .o_valid  (o_out_valid),
        .o_volt_d (o_volt_d),
        .o_volt_q (o_volt_q)
    );

    // a sample request starts the lane sequence
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_SAMPLE)) |=> (r_state == S_MUL))
        else $error("sample request did not start lane sequence");

    // a set-ref request leaves the sequencer idle
    a_ref_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_SET_REF)) |=> (r_state == S_IDLE))
        else $error("set-ref request left idle");

    // a full, stalled slot holds the sequence in hand-over
    a_merge_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MERGE) && o_out_valid && !i_out_ready) |=> (r_state == S_MERGE))
        else $error("result overwritten while held");

    // a new result only appears after the hand-over step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_MERGE))
        else $error("result raised outside hand-over");

endmodule

// ----- dv/tb_dq_current_pi_regulator.sv -----
`timescale 1ns / 100ps

module tb_dq_current_pi_regulator;

    import dqpi_pkg::*;

    localparam int CW   = CURRENT_WIDTH_DEF;
    localparam int AX_D = 0;
    localparam int AX_Q = 1;
    // extra cycles after the last result: covers a set-ref still in flight
    localparam int SETTLE_CYCLES = 10;

    // ---------------------------------------------------------------
    // Clock, reset and block inputs; everything known from time zero
    // ---------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  i_cmd      = CMD_SET_REF;
    logic signed [CW-1:0]  i_target_q = '0;
    logic signed [CW-1:0]  i_target_d = '0;
    logic signed [CW-1:0]  i_meas_d   = '0;
    logic signed [CW-1:0]  i_meas_q   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic signed [VOLT_W-1:0] o_volt_d;
    logic signed [VOLT_W-1:0] o_volt_q;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dq_current_pi_regulator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_target_q  (i_target_q),
        .i_target_d  (i_target_d),
        .i_meas_d    (i_meas_d),
        .i_meas_q    (i_meas_q),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_volt_d    (o_volt_d),
        .o_volt_q    (o_volt_q)
    );

    // ---------------------------------------------------------------
    // Regulator predictor: own copy of gains, limits and loop state.
    // Index AX_D / AX_Q selects the axis.
    // ---------------------------------------------------------------
    longint kp_gain, ki_gain, integ_lim, cur_lim;
    longint ref_st   [2];
    longint filt_st  [2];
    longint integ_st [2];

    typedef struct {
        logic signed [VOLT_W-1:0] vd;
        logic signed [VOLT_W-1:0] vq;
    } t_volts;

    t_volts volt_expected_q [$];

    int  mismatches;
    int  n_samples, n_refs, n_cfg, n_checked;
    bit  gaps_on = 1'b1;
    int  stall_left;

    function automatic longint limit(longint v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // One PI step on one axis: low-pass, error, clamped integrator, output.
    // All shifts are arithmetic on signed 64-bit, i.e. floor rounding.
    function automatic logic signed [VOLT_W-1:0] regulate_axis(int ax,
                                                               logic signed [CW-1:0] meas);
        longint f, err, acc, v;
        f = (longint'(FILT_NEW) * longint'(meas) + longint'(FILT_OLD) * filt_st[ax]) >>> 15;
        filt_st[ax] = f;
        err = ref_st[ax] - f;
        acc = integ_st[ax] + ((err * ki_gain * kp_gain) >>> 16);
        integ_st[ax] = limit(acc, -integ_lim, integ_lim);
        v = integ_st[ax] + ((kp_gain * err) >>> 4);
        v = limit(v, -(longint'(1) << (VOLT_W - 1)), (longint'(1) << (VOLT_W - 1)) - 1);
        return v[VOLT_W-1:0];
    endfunction

    function automatic void reset_predictor();
        kp_gain   = PROP_GAIN_RST;
        ki_gain   = INTEG_GAIN_RST;
        integ_lim = INTEG_LIMIT_RST;
        cur_lim   = CURRENT_LIMIT_RST;
        for (int a = 0; a < 2; a++) begin
            ref_st[a]   = 0;
            filt_st[a]  = 0;
            integ_st[a] = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic signed [CW-1:0] pick_current();
        logic signed [CW-1:0] corners [5];
        int r;
        corners = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001};
        r = $urandom_range(0, 9);
        if (r < 2) return corners[$urandom_range(0, 4)];
        if (r < 5) return CW'($urandom_range(0, 4095) - 2048);
        return CW'($urandom());
    endfunction

    function automatic int unsigned pick_setting(int unsigned top);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    // Send one request; the prediction is made at the accepting edge.
    // Valid is left high afterwards so back-to-back requests need no
    // second assignment in a step; wait_idle or a gap lowers it.
    task automatic send_request(logic cmd, logic signed [CW-1:0] tq,
                                logic signed [CW-1:0] td, logic signed [CW-1:0] md,
                                logic signed [CW-1:0] mq);
        t_volts e;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_target_q <= tq;
        i_target_d <= td;
        i_meas_d   <= md;
        i_meas_q   <= mq;
        do @(posedge i_clk); while (!o_in_ready);
        if (cmd == CMD_SET_REF) begin
            ref_st[AX_Q] = limit(longint'(tq), -cur_lim, cur_lim);
            ref_st[AX_D] = limit(longint'(td), -cur_lim, cur_lim);
            n_refs++;
        end else begin
            e.vd = regulate_axis(AX_D, md);
            e.vq = regulate_axis(AX_Q, mq);
            volt_expected_q.push_back(e);
            n_samples++;
        end
    endtask

    // unused fields carry random content; the block must ignore them
    task automatic set_refs(logic signed [CW-1:0] td, logic signed [CW-1:0] tq);
        send_request(CMD_SET_REF, tq, td, CW'($urandom()), CW'($urandom()));
    endtask

    task automatic send_sample(logic signed [CW-1:0] md, logic signed [CW-1:0] mq);
        send_request(CMD_SAMPLE, CW'($urandom()), CW'($urandom()), md, mq);
    endtask

    // Hold off until every expected result is back and the block is quiet
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (volt_expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PROP_GAIN:     kp_gain   = value & 32'hffff;
            REG_INTEG_GAIN:    ki_gain   = value & 32'hffff;
            REG_INTEG_LIMIT:   integ_lim = value & 32'hff_ffff;
            REG_CURRENT_LIMIT: cur_lim   = value & 32'h7fff;
            default: ;
        endcase
        n_cfg++;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(int unsigned kp, int unsigned ki,
                                  int unsigned ilim, int unsigned clim);
        wait_idle();
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_INTEG_LIMIT, ilim);
        write_reg(REG_CURRENT_LIMIT, clim);
    endtask

    // ---------------------------------------------------------------
    // Result checker and receiver back-pressure
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (volt_expected_q.size() == 0) begin
                $error("result with no request outstanding: volt_d %0d volt_q %0d",
                       o_volt_d, o_volt_q);
                mismatches++;
            end else begin
                t_volts e;
                e = volt_expected_q.pop_front();
                n_checked++;
                if (o_volt_d !== e.vd) begin
                    $error("volt_d: expected %0d, got %0d", e.vd, o_volt_d);
                    mismatches++;
                end
                if (o_volt_q !== e.vq) begin
                    $error("volt_q: expected %0d, got %0d", e.vq, o_volt_q);
                    mismatches++;
                end
            end
        end
        // random stall bursts, none once gaps are switched off
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // defaults straight out of reset, references still zero
    task automatic test_reset_values();
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
    endtask

    // targets beyond the default 40 A limit get clamped on both axes
    task automatic test_reference_clamp();
        set_refs(16'sh7fff, 16'sh8000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0100, 16'shff00);
        set_refs(16'sh8000, 16'sh7fff);
        send_sample(16'shffff, 16'sh0001);
    endtask

    // zero current limit: every reference collapses to zero
    task automatic test_zero_current_limit();
        wait_idle();
        write_reg(REG_CURRENT_LIMIT, 0);
        set_refs(16'sh7fff, 16'sh8000);
        send_sample(16'sh1234, 16'shedcb);
        send_sample(16'sh8000, 16'sh7fff);
    endtask

    // zero integrator limit: integrators pinned, output is the P term only
    task automatic test_zero_integ_limit();
        apply_settings(4096, 4096, 0, CURRENT_LIMIT_RST);
        set_refs(16'sh2000, 16'she000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
    endtask

    // full-scale gains and limits, largest error: integrator hits its
    // clamp and the voltage runs at either end of its reachable range
    task automatic test_saturation();
        apply_settings(16'hffff, 16'hffff, 24'hff_ffff, 15'h7fff);
        set_refs(16'sh7fff, 16'sh8000);
        repeat (4) send_sample(16'sh8000, 16'sh7fff);
        set_refs(16'sh8000, 16'sh7fff);
        repeat (4) send_sample(16'sh7fff, 16'sh8000);
    endtask

    // Random traffic over several register settings. Mostly samples that
    // track the reference so the integrator works inside its clamp, with
    // reference updates and wild samples mixed in. Request gaps and
    // receiver stalls stop in the last phase.
    task automatic test_random_traffic();
        int r;
        logic signed [CW-1:0] md, mq;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_settings(0, 0, 0, 0);
                1: apply_settings(16'hffff, 16'hffff, 24'hff_ffff, 15'h7fff);
                2: apply_settings(PROP_GAIN_RST, INTEG_GAIN_RST, INTEG_LIMIT_RST,
                                  CURRENT_LIMIT_RST);
                default: apply_settings(pick_setting(16'hffff), pick_setting(16'hffff),
                                        pick_setting(24'hff_ffff), pick_setting(15'h7fff));
            endcase
            if (ph == 7)
                gaps_on = 1'b0;
            for (int k = 0; k < 220; k++) begin
                // now and then the sender waits for every result to drain
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    set_refs(pick_current(), pick_current());
                end else if (r < 7) begin
                    md = CW'(ref_st[AX_D] + longint'($urandom_range(0, 1023)) - 512);
                    mq = CW'(ref_st[AX_Q] + longint'($urandom_range(0, 1023)) - 512);
                    send_sample(md, mq);
                end else begin
                    send_sample(pick_current(), pick_current());
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        reset_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_reference_clamp();
        test_zero_current_limit();
        test_zero_integ_limit();
        test_saturation();
        test_random_traffic();
        wait_idle();

        $display("run covered %0d samples and %0d reference updates over %0d register writes",
                 n_samples, n_refs, n_cfg);
        $display("%0d voltage pairs checked, %0d mismatches", n_checked, mismatches);
        if (mismatches == 0)
            $display("tb_dq_current_pi_regulator passed");
        else
            $display("tb_dq_current_pi_regulator failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb_dq_current_pi_regulator failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/dqpi_pkg.sv
hdl/dqpi_lane.sv
hdl/dqpi_merge.sv
hdl/dq_current_pi_regulator.sv
dv/tb_dq_current_pi_regulator.sv
